// ----- rtl/ascu_pkg.sv -----
// ----------------------------------------------------------------------------
// Analog stick conditioner package
// Shared request and response types, lane interface types, arithmetic
// constants and the response curve table.
// ----------------------------------------------------------------------------
package ascu_pkg;

   localparam int CURVE_TABLE_DEPTH = 256;
   localparam int SCREEN_WIDTH      = 1920;
   localparam int SCREEN_HEIGHT     = 1080;

   localparam int CURVE_AW = $clog2(CURVE_TABLE_DEPTH);
   localparam int CURVE_PW = 16 + CURVE_AW;
   localparam int SCREEN_W_BITS = $clog2(SCREEN_WIDTH + 1);
   localparam int SCREEN_H_BITS = $clog2(SCREEN_HEIGHT + 1);
   localparam int PIX_X_PW = 20 + ((SCREEN_W_BITS > 11) ? SCREEN_W_BITS : 11);
   localparam int PIX_Y_PW = 20 + ((SCREEN_H_BITS > 11) ? SCREEN_H_BITS : 11);

   localparam longint unsigned CURVE_DIV = CURVE_TABLE_DEPTH - 1;

   localparam longint unsigned DZ_MOVE = 4915;
   localparam longint unsigned DZ_LOOK = 3932;
   localparam longint unsigned DZ_DIV_MOVE = 32768 - DZ_MOVE;
   localparam longint unsigned DZ_DIV_LOOK = 32768 - DZ_LOOK;
   localparam logic [30:0] RECIP_MOVE =
      31'(((64'd1 << 45) + DZ_DIV_MOVE - 64'd1) / DZ_DIV_MOVE);
   localparam logic [30:0] RECIP_LOOK =
      31'(((64'd1 << 45) + DZ_DIV_LOOK - 64'd1) / DZ_DIV_LOOK);

   localparam longint unsigned CURSOR_DIV = 625;
   localparam logic [31:0] CURSOR_RECIP =
      32'(((64'd1 << 41) + CURSOR_DIV - 64'd1) / CURSOR_DIV);
   localparam longint unsigned REM_RECIP =
      ((64'd1 << 23) + CURSOR_DIV - 64'd1) / CURSOR_DIV;
   localparam logic [17:0] REM_RECIP_12 = 18'(REM_RECIP * 64'd12);

   localparam logic [15:0] DIR_MIN    = 16'd33;
   localparam logic [19:0] FULL_SCALE = 20'd524288;
   localparam logic [19:0] FX_RESET   = 20'd209715;
   localparam logic [19:0] FY_RESET   = 20'd262144;

   localparam logic [10:0] SENS_MIN   = 11'd13;
   localparam logic [10:0] SENS_MAX   = 11'd1280;
   localparam logic [10:0] SENS_RESET = 11'd256;

   localparam logic [2:0] CSR_SENS_H   = 3'd0;
   localparam logic [2:0] CSR_SENS_V   = 3'd1;
   localparam logic [2:0] CSR_INVERT_Y = 3'd2;
   localparam logic [2:0] CSR_CURVE    = 3'd3;
   localparam logic [2:0] CSR_TOUCH    = 3'd4;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_REL    = 2'd1;
   localparam logic [1:0] KIND_CURSOR = 2'd2;

   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic               side;
      logic               gated;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic [15:0]        elapsed_ms;
      logic               ui_mode;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         key_index;
      logic               key_down;
      logic [10:0]        cursor_px;
      logic [10:0]        cursor_py;
      logic signed [11:0] delta_x;
      logic signed [11:0] delta_y;
      logic [3:0]         held_keys;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        look;
      logic        curve_en;
      logic [10:0] sens;
      logic [15:0] elapsed;
   } lane_cfg_type;

   typedef struct packed {
      logic        valid;
      logic        neg;
      logic [15:0] mag;
      logic [10:0] mouse;
      logic [25:0] step;
   } lane_res_type;

   typedef logic [15:0] curve_rom_type [CURVE_TABLE_DEPTH];

   function automatic longint unsigned isqrt64(longint unsigned n_in);
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      n = n_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic curve_rom_type build_curve();
      curve_rom_type   rom;
      longint unsigned one;
      longint unsigned qq;
      longint unsigned rr;
      longint unsigned i;
      longint unsigned x;
      longint unsigned s;
      longint unsigned q;
      one = 64'd1 << 60;
      qq  = one / CURVE_DIV;
      rr  = one % CURVE_DIV;
      for (int k = 0; k < CURVE_TABLE_DEPTH; k++) begin
         i = longint'(k);
         x = i * qq + (i * rr) / CURVE_DIV;
         s = isqrt64(x);
         q = isqrt64(s << 2);
         rom[k] = 16'(((i * q) / CURVE_DIV) >> 1);
      end
      return rom;
   endfunction

   localparam curve_rom_type CURVE_ROM = build_curve();

endpackage

// ----- rtl/ascu_lane.sv -----
// ----------------------------------------------------------------------------
// Analog stick conditioner axis lane
// Per-axis pipeline: deadzone rescale, response curve interpolation,
// sensitivity scaling for mouse deltas and cursor step computation.
// ----------------------------------------------------------------------------
module ascu_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [15:0]     value,
   input  ascu_pkg::lane_cfg_type cfg,
   output ascu_pkg::lane_res_type res
);

   logic [9:1] vld_ff;
   ascu_pkg::lane_cfg_type cfg_ff;

   logic [16:0] ext_in;
   logic [16:0] mag_in;
   logic [16:0] dz_in;
   logic [14:0] a_in;
   logic [30:0] recip_in;
   logic [45:0] prod1_ff;
   logic        neg1_ff;

   logic [ascu_pkg::CURVE_PW-1:0] p_in;
   logic [ascu_pkg::CURVE_AW-1:0] idx2_ff;
   logic [14:0] f2_ff;
   logic [15:0] dzv2_ff;
   logic        neg2_ff;

   logic        top_in;
   logic [15:0] e0_in;
   logic [15:0] e1_in;
   logic [15:0] e0_3_ff;
   logic [15:0] diff3_ff;
   logic [14:0] f3_ff;
   logic [15:0] dzv3_ff;
   logic        neg3_ff;

   logic [30:0] prodc4_ff;
   logic [15:0] e0_4_ff;
   logic [15:0] dzv4_ff;
   logic        neg4_ff;

   logic [15:0] c_in;
   logic [15:0] c5_ff;
   logic        neg5_ff;

   logic [26:0] cs6_ff;
   logic [30:0] cm6_ff;
   logic [15:0] c6_ff;
   logic        neg6_ff;

   logic [34:0] ms_in;
   logic [10:0] mouse7_ff;
   logic [62:0] prod7_ff;
   logic [30:0] cm7_ff;
   logic [15:0] c7_ff;
   logic        neg7_ff;

   logic [21:0] qm_in;
   logic [30:0] rm_in;
   logic [21:0] qm8_ff;
   logic [9:0]  rm8_ff;
   logic [10:0] mouse8_ff;
   logic [15:0] c8_ff;
   logic        neg8_ff;

   logic [27:0] t_in;
   logic [25:0] step9_ff;
   logic [10:0] mouse9_ff;
   logic [15:0] c9_ff;
   logic        neg9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[8:1], start};
      end
   end

   assign ext_in   = {value[15], value};
   assign mag_in   = value[15] ? (~ext_in + 17'd1) : ext_in;
   assign dz_in    = cfg.look ? 17'(ascu_pkg::DZ_LOOK) : 17'(ascu_pkg::DZ_MOVE);
   assign a_in     = (mag_in > dz_in) ? 15'(mag_in - dz_in) : 15'd0;
   assign recip_in = cfg.look ? ascu_pkg::RECIP_LOOK : ascu_pkg::RECIP_MOVE;

   assign p_in = ascu_pkg::CURVE_PW'(prod1_ff[45:30])
               * ascu_pkg::CURVE_PW'(ascu_pkg::CURVE_TABLE_DEPTH - 1);

   assign top_in = (idx2_ff == ascu_pkg::CURVE_AW'(ascu_pkg::CURVE_TABLE_DEPTH - 1));
   assign e0_in  = ascu_pkg::CURVE_ROM[idx2_ff];
   assign e1_in  = top_in ? e0_in : ascu_pkg::CURVE_ROM[idx2_ff + ascu_pkg::CURVE_AW'(1)];

   assign c_in = cfg_ff.curve_en ? (e0_4_ff + prodc4_ff[30:15]) : dzv4_ff;

   assign ms_in = 35'(cs6_ff) * 35'd260;

   assign qm_in = prod7_ff[62:41];
   assign rm_in = cm7_ff - 31'(qm_in * 22'(ascu_pkg::CURSOR_DIV));

   assign t_in = 28'(rm8_ff) * 28'(ascu_pkg::REM_RECIP_12);

   always_ff @(posedge clock) begin
      if (start) begin
         cfg_ff <= cfg;
      end
      prod1_ff <= 46'(a_in) * 46'(recip_in);
      neg1_ff  <= value[15];

      idx2_ff <= p_in[15 +: ascu_pkg::CURVE_AW];
      f2_ff   <= p_in[14:0];
      dzv2_ff <= prod1_ff[45:30];
      neg2_ff <= neg1_ff;

      e0_3_ff  <= e0_in;
      diff3_ff <= e1_in - e0_in;
      f3_ff    <= f2_ff;
      dzv3_ff  <= dzv2_ff;
      neg3_ff  <= neg2_ff;

      prodc4_ff <= 31'(diff3_ff) * 31'(f3_ff);
      e0_4_ff   <= e0_3_ff;
      dzv4_ff   <= dzv3_ff;
      neg4_ff   <= neg3_ff;

      c5_ff   <= c_in;
      neg5_ff <= neg4_ff;

      cs6_ff  <= 27'(c5_ff) * 27'(cfg_ff.sens);
      cm6_ff  <= 31'(c5_ff) * 31'(cfg_ff.elapsed);
      c6_ff   <= c5_ff;
      neg6_ff <= neg5_ff;

      mouse7_ff <= ms_in[33:23];
      prod7_ff  <= 63'(cm6_ff) * 63'(ascu_pkg::CURSOR_RECIP);
      cm7_ff    <= cm6_ff;
      c7_ff     <= c6_ff;
      neg7_ff   <= neg6_ff;

      qm8_ff    <= qm_in;
      rm8_ff    <= rm_in[9:0];
      mouse8_ff <= mouse7_ff;
      c8_ff     <= c7_ff;
      neg8_ff   <= neg7_ff;

      step9_ff  <= 26'(qm8_ff) * 26'd12 + 26'(t_in[27:23]);
      mouse9_ff <= mouse8_ff;
      c9_ff     <= c8_ff;
      neg9_ff   <= neg8_ff;
   end

   assign res.valid = vld_ff[9];
   assign res.neg   = neg9_ff;
   assign res.mag   = c9_ff;
   assign res.mouse = mouse9_ff;
   assign res.step  = step9_ff;

endmodule

// ----- rtl/analog_stick_conditioner_unit.sv -----
// ----------------------------------------------------------------------------
// Analog stick conditioner
// Turns two-axis stick samples into key, relative mouse and absolute cursor
// events through two axis lanes and a merging controller.
//
//  Channel  Ports                        Direction  Payload
//  request  req_valid/req_stall/req_data in         ascu_pkg::req_type
//  response rsp_valid/rsp_stall/rsp_data out        ascu_pkg::rsp_type
//  config   csr_valid/csr_ready/...      in         index 3 bits, data 11 bits
//
// A stick sample passes the lane pipelines, then each movement key is checked
// (up to four), a mouse delta is sent or the cursor is integrated, scaled and
// sent. A release command skips the lanes. One request is in work at a time;
// the next is taken while the final response waits in the output register.
// Reset is synchronous and sets the documented register defaults.
// ----------------------------------------------------------------------------
module analog_stick_conditioner_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ascu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ascu_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [10:0]       csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_BUSY, ST_KEYS, ST_MOUSE, ST_CURSOR, ST_SCALE, ST_PIXEL
   } state_type;

   state_type         state_ff;
   logic [10:0]       sens_h_ff;
   logic [10:0]       sens_v_ff;
   logic              invert_y_ff;
   logic              curve_ff;
   logic              touch_ff;
   logic [3:0]        held_ff;
   logic [19:0]       fx_ff;
   logic [19:0]       fy_ff;
   logic              side_ff;
   logic              ui_ff;
   logic [3:0]        target_ff;
   logic [3:0]        chg_ff;
   logic [1:0]        idx_ff;
   logic signed [11:0] mx_ff;
   logic signed [11:0] my_ff;
   logic signed [26:0] stx_ff;
   logic signed [26:0] sty_ff;
   logic [ascu_pkg::PIX_X_PW-1:0] pxp_ff;
   logic [ascu_pkg::PIX_Y_PW-1:0] pyp_ff;
   logic              rsp_valid_ff;
   ascu_pkg::rsp_type rsp_ff;

   logic              accept_in;
   logic              drop_in;
   logic              lane_start_in;
   logic              out_free_in;
   logic              rsp_load_in;
   ascu_pkg::lane_cfg_type cfg_x_in;
   ascu_pkg::lane_cfg_type cfg_y_in;
   ascu_pkg::lane_res_type res_x;
   ascu_pkg::lane_res_type res_y;
   logic [3:0]        move_in;
   logic [10:0]       sens_in;
   logic [3:0]        held_key_in;
   logic              last_key_in;
   logic signed [28:0] sumx_in;
   logic signed [28:0] sumy_in;
   logic [19:0]       fx_in;
   logic [19:0]       fy_in;
   logic signed [11:0] mx_in;
   logic signed [11:0] my_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept_in = req_valid && !req_stall;
   assign drop_in   = req_data.gated && !touch_ff;
   assign lane_start_in = accept_in && (req_data.cmd == ascu_pkg::CMD_SAMPLE) && !drop_in;
   assign out_free_in = !rsp_valid_ff || !rsp_stall;
   assign rsp_load_in = out_free_in && (((state_ff == ST_KEYS) && chg_ff[idx_ff]) ||
                                        (state_ff == ST_MOUSE) || (state_ff == ST_PIXEL));
   assign csr_ready = 1'b1;

   assign cfg_x_in.look     = req_data.side;
   assign cfg_x_in.curve_en = req_data.side && curve_ff;
   assign cfg_x_in.sens     = sens_h_ff;
   assign cfg_x_in.elapsed  = req_data.elapsed_ms;
   assign cfg_y_in.look     = req_data.side;
   assign cfg_y_in.curve_en = req_data.side && curve_ff;
   assign cfg_y_in.sens     = sens_v_ff;
   assign cfg_y_in.elapsed  = req_data.elapsed_ms;

   ascu_lane u_lane_x (
      .clock (clock),
      .reset (reset),
      .start (lane_start_in),
      .value (req_data.axis_x),
      .cfg   (cfg_x_in),
      .res   (res_x)
   );

   ascu_lane u_lane_y (
      .clock (clock),
      .reset (reset),
      .start (lane_start_in),
      .value (req_data.axis_y),
      .cfg   (cfg_y_in),
      .res   (res_y)
   );

   assign move_in[0] = res_y.neg && (res_y.mag >= ascu_pkg::DIR_MIN);
   assign move_in[1] = !res_y.neg && (res_y.mag >= ascu_pkg::DIR_MIN);
   assign move_in[2] = res_x.neg && (res_x.mag >= ascu_pkg::DIR_MIN);
   assign move_in[3] = !res_x.neg && (res_x.mag >= ascu_pkg::DIR_MIN);

   assign mx_in = res_x.neg ? -$signed({1'b0, res_x.mouse}) : $signed({1'b0, res_x.mouse});
   assign my_in = (res_y.neg ^ invert_y_ff) ? -$signed({1'b0, res_y.mouse})
                                            : $signed({1'b0, res_y.mouse});

   assign sens_in = (csr_data < ascu_pkg::SENS_MIN) ? ascu_pkg::SENS_MIN :
                    (csr_data > ascu_pkg::SENS_MAX) ? ascu_pkg::SENS_MAX : csr_data;

   assign held_key_in = held_ff ^ (4'd1 << idx_ff);
   assign last_key_in = (((chg_ff >> idx_ff) >> 1) == 4'd0);

   assign sumx_in = $signed({9'd0, fx_ff}) + 29'(stx_ff);
   assign sumy_in = $signed({9'd0, fy_ff}) + 29'(sty_ff);
   assign fx_in = (sumx_in < 0) ? 20'd0 :
                  (sumx_in > $signed({9'd0, ascu_pkg::FULL_SCALE})) ? ascu_pkg::FULL_SCALE :
                  sumx_in[19:0];
   assign fy_in = (sumy_in < 0) ? 20'd0 :
                  (sumy_in > $signed({9'd0, ascu_pkg::FULL_SCALE})) ? ascu_pkg::FULL_SCALE :
                  sumy_in[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sens_h_ff    <= ascu_pkg::SENS_RESET;
         sens_v_ff    <= ascu_pkg::SENS_RESET;
         invert_y_ff  <= 1'b0;
         curve_ff     <= 1'b1;
         touch_ff     <= 1'b1;
         held_ff      <= 4'd0;
         fx_ff        <= ascu_pkg::FX_RESET;
         fy_ff        <= ascu_pkg::FY_RESET;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load_in) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ascu_pkg::CSR_SENS_H:   sens_h_ff <= sens_in;
               ascu_pkg::CSR_SENS_V:   sens_v_ff <= sens_in;
               ascu_pkg::CSR_INVERT_Y: invert_y_ff <= csr_data[0];
               ascu_pkg::CSR_CURVE:    curve_ff <= csr_data[0];
               ascu_pkg::CSR_TOUCH: begin
                  if (touch_ff && !csr_data[0]) begin
                     held_ff <= 4'd0;
                  end
                  touch_ff <= csr_data[0];
               end
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  side_ff <= req_data.side;
                  ui_ff   <= req_data.ui_mode;
                  idx_ff  <= 2'd0;
                  if (req_data.cmd == ascu_pkg::CMD_RELEASE) begin
                     target_ff <= 4'd0;
                     chg_ff    <= held_ff;
                     if (!touch_ff) begin
                        held_ff <= 4'd0;
                     end else if (held_ff != 4'd0) begin
                        state_ff <= ST_KEYS;
                     end
                  end else if (!drop_in) begin
                     state_ff <= ST_BUSY;
                  end
               end
            end
            ST_BUSY: begin
               if (res_x.valid) begin
                  mx_ff  <= mx_in;
                  my_ff  <= my_in;
                  stx_ff <= res_x.neg ? -$signed({1'b0, res_x.step})
                                      : $signed({1'b0, res_x.step});
                  sty_ff <= res_y.neg ? -$signed({1'b0, res_y.step})
                                      : $signed({1'b0, res_y.step});
                  target_ff <= move_in;
                  chg_ff    <= held_ff ^ move_in;
                  if (!side_ff) begin
                     if (!touch_ff) begin
                        held_ff  <= move_in;
                        state_ff <= ST_IDLE;
                     end else if ((held_ff ^ move_in) != 4'd0) begin
                        state_ff <= ST_KEYS;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end else if (ui_ff) begin
                     state_ff <= ST_CURSOR;
                  end else if (touch_ff) begin
                     state_ff <= ST_MOUSE;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_KEYS: begin
               if (!chg_ff[idx_ff]) begin
                  idx_ff <= idx_ff + 2'd1;
               end else if (out_free_in) begin
                  held_ff      <= held_key_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{kind: ascu_pkg::KIND_KEY, key_index: idx_ff,
                              key_down: target_ff[idx_ff], held_keys: held_key_in,
                              last: last_key_in, default: '0};
                  idx_ff <= idx_ff + 2'd1;
                  if (last_key_in) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_MOUSE: begin
               if (out_free_in) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{kind: ascu_pkg::KIND_REL, delta_x: mx_ff, delta_y: my_ff,
                              held_keys: held_ff, last: 1'b1, default: '0};
                  state_ff <= ST_IDLE;
               end
            end
            ST_CURSOR: begin
               fx_ff    <= fx_in;
               fy_ff    <= fy_in;
               state_ff <= touch_ff ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: begin
               pxp_ff   <= ascu_pkg::PIX_X_PW'(fx_ff)
                         * ascu_pkg::PIX_X_PW'(ascu_pkg::SCREEN_WIDTH);
               pyp_ff   <= ascu_pkg::PIX_Y_PW'(fy_ff)
                         * ascu_pkg::PIX_Y_PW'(ascu_pkg::SCREEN_HEIGHT);
               state_ff <= ST_PIXEL;
            end
            ST_PIXEL: begin
               if (out_free_in) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{kind: ascu_pkg::KIND_CURSOR, cursor_px: pxp_ff[19 +: 11],
                              cursor_py: pyp_ff[19 +: 11], held_keys: held_ff,
                              last: 1'b1, default: '0};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Analog stick conditioner testbench
// Drives stick samples and release commands through the request channel and
// checks every response against a behavioral prediction of the deadzone,
// response curve, key tracking, mouse delta and cursor integration. Register
// settings change between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ascu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [10:0]   csr_data;

   req_type       pending_requests[$];
   rsp_type       expected_events[$];
   int            mismatch_count;
   int            cycle_count;
   bit            calm_mode;
   bit            req_taken;

   logic [15:0]   curve_table[CURVE_TABLE_DEPTH];
   logic [10:0]   sens_h_q;
   logic [10:0]   sens_v_q;
   logic          invert_y_q;
   logic          look_curve_q;
   logic          touch_q;
   logic [3:0]    held_q;
   longint        cursor_x_q;
   longint        cursor_y_q;

   analog_stick_conditioner_unit DUT (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n_in);
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      n = n_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic fill_curve_table();
      longint unsigned d;
      longint unsigned qq;
      longint unsigned rr;
      longint unsigned x;
      longint unsigned q;
      d = CURVE_TABLE_DEPTH - 1;
      qq = (64'd1 << 60) / d;
      rr = (64'd1 << 60) % d;
      for (longint unsigned i = 0; i < CURVE_TABLE_DEPTH; i++) begin
         x = i * qq + (i * rr) / d;
         q = int_sqrt(int_sqrt(x) << 2);
         curve_table[i] = 16'(((i * q) / d) >> 1);
      end
   endtask

   function automatic longint apply_deadzone(longint v, longint dz);
      if (v > dz) return ((v - dz) * 32768) / (32768 - dz);
      if (v < -dz) return ((v + dz) * 32768) / (32768 - dz);
      return 0;
   endfunction

   function automatic longint apply_curve(longint v);
      longint a;
      longint p;
      longint i;
      longint m;
      if (!look_curve_q || v == 0) return v;
      a = v < 0 ? -v : v;
      p = a * (CURVE_TABLE_DEPTH - 1);
      i = p >>> 15;
      if (i >= CURVE_TABLE_DEPTH - 1) begin
         m = curve_table[CURVE_TABLE_DEPTH - 1];
      end else begin
         m = longint'(curve_table[i]) +
             (((longint'(curve_table[i + 1]) - longint'(curve_table[i])) * (p & 32767))
              >>> 15);
      end
      return v < 0 ? -m : m;
   endfunction

   function automatic longint div_toward_zero(longint n, longint d);
      return n < 0 ? -((-n) / d) : n / d;
   endfunction

   function automatic longint clamp_cursor(longint v);
      if (v < 0) return 0;
      if (v > 524288) return 524288;
      return v;
   endfunction

   function automatic rsp_type blank_event(logic [1:0] kind);
      rsp_type r;
      r = '0;
      r.kind = kind;
      return r;
   endfunction

   task automatic track_key(int idx, bit down, bit emit, inout rsp_type evs[$]);
      rsp_type r;
      if (held_q[idx] == down) return;
      held_q[idx] = down;
      if (!emit) return;
      r = blank_event(KIND_KEY);
      r.key_index = 2'(idx);
      r.key_down = down;
      r.held_keys = held_q;
      evs.push_back(r);
   endtask

   task automatic predict_events(req_type q);
      rsp_type evs[$];
      rsp_type r;
      longint  dx;
      longint  dy;
      longint  cx;
      longint  cy;
      longint  mx;
      longint  my;
      bit      emit;
      emit = touch_q;
      if (q.cmd == CMD_RELEASE) begin
         for (int i = 0; i < 4; i++) track_key(i, 1'b0, emit, evs);
      end else if (q.gated && !touch_q) begin
         return;
      end else if (!q.side) begin
         dx = apply_deadzone(q.axis_x, DZ_MOVE);
         dy = apply_deadzone(q.axis_y, DZ_MOVE);
         track_key(0, dy <= -33, emit, evs);
         track_key(1, dy >= 33, emit, evs);
         track_key(2, dx <= -33, emit, evs);
         track_key(3, dx >= 33, emit, evs);
      end else begin
         cx = apply_curve(apply_deadzone(q.axis_x, DZ_LOOK));
         cy = apply_curve(apply_deadzone(q.axis_y, DZ_LOOK));
         if (!q.ui_mode) begin
            mx = div_toward_zero(cx * sens_h_q * 260, 64'sd1 << 23);
            my = div_toward_zero(cy * sens_v_q * 260, 64'sd1 << 23);
            if (invert_y_q) my = -my;
            r = blank_event(KIND_REL);
            r.delta_x = 12'(mx);
            r.delta_y = 12'(my);
         end else begin
            cursor_x_q = clamp_cursor(cursor_x_q +
                                      div_toward_zero(cx * q.elapsed_ms * 12, 625));
            cursor_y_q = clamp_cursor(cursor_y_q +
                                      div_toward_zero(cy * q.elapsed_ms * 12, 625));
            r = blank_event(KIND_CURSOR);
            r.cursor_px = 11'((cursor_x_q * SCREEN_WIDTH) >>> 19);
            r.cursor_py = 11'((cursor_y_q * SCREEN_HEIGHT) >>> 19);
         end
         r.held_keys = held_q;
         if (emit) evs.push_back(r);
      end
      if (evs.size() > 0) evs[$].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   function automatic logic [10:0] clamp_sens(logic [10:0] v);
      if (v < SENS_MIN) return SENS_MIN;
      if (v > SENS_MAX) return SENS_MAX;
      return v;
   endfunction

   task automatic write_register(logic [2:0] idx, logic [10:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SENS_H:   sens_h_q = clamp_sens(value);
         CSR_SENS_V:   sens_v_q = clamp_sens(value);
         CSR_INVERT_Y: invert_y_q = value[0];
         CSR_CURVE:    look_curve_q = value[0];
         CSR_TOUCH: begin
            if (touch_q && !value[0]) held_q = '0;
            touch_q = value[0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 9000)) - 16'sd4500;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.cmd = $urandom_range(0, 9) == 0;
      q.side = $urandom_range(0, 1);
      q.gated = $urandom_range(0, 1);
      q.axis_x = random_axis();
      q.axis_y = random_axis();
      q.elapsed_ms = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
      q.ui_mode = $urandom_range(0, 1);
      return q;
   endfunction

   function automatic req_type make_sample(logic side, logic signed [15:0] x,
                                           logic signed [15:0] y, logic ui,
                                           logic [15:0] ms);
      req_type q;
      q = '0;
      q.cmd = CMD_SAMPLE;
      q.side = side;
      q.axis_x = x;
      q.axis_y = y;
      q.ui_mode = ui;
      q.elapsed_ms = ms;
      return q;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= calm_mode ? 1'b0 : ($urandom_range(0, 99) < 6);
         if (!req_valid || req_taken) begin
            if (pending_requests.size() > 0 &&
                (calm_mode || $urandom_range(0, 99) >= 6)) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) predict_events(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %p", rsp_data);
         end else if (rsp_data !== expected_events[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %p actual %p", expected_events[0], rsp_data);
            void'(expected_events.pop_front());
         end else begin
            void'(expected_events.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      req_type q;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatch_count = 0;
      cycle_count = 0;
      calm_mode = 1'b0;
      fill_curve_table();
      sens_h_q = SENS_RESET;
      sens_v_q = SENS_RESET;
      invert_y_q = 1'b0;
      look_curve_q = 1'b1;
      touch_q = 1'b1;
      held_q = '0;
      cursor_x_q = FX_RESET;
      cursor_y_q = FY_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pending_requests.push_back(make_sample(0, 16'sh8000, 16'sh8000, 0, 0));
      pending_requests.push_back(make_sample(0, 16'sh7fff, 16'sh7fff, 0, 0));
      pending_requests.push_back(make_sample(0, 16'sd4915, -16'sd4949, 0, 0));
      pending_requests.push_back(make_sample(0, 16'sd4949, -16'sd4950, 0, 0));
      q = '0;
      q.cmd = CMD_RELEASE;
      pending_requests.push_back(q);
      pending_requests.push_back(make_sample(1, 16'sh7fff, 16'sh8000, 0, 0));
      pending_requests.push_back(make_sample(1, 16'sd3932, -16'sd3933, 0, 0));
      pending_requests.push_back(make_sample(1, 16'sh7fff, 16'sh7fff, 1, 16'hffff));
      pending_requests.push_back(make_sample(1, 16'sh8000, 16'sh8000, 1, 16'hffff));
      pending_requests.push_back(make_sample(1, 16'sd9000, -16'sd7000, 1, 16'd17));
      pending_requests.push_back(make_sample(0, 16'sh8000, 16'sd0, 0, 0));
      wait_idle();

      write_register(CSR_TOUCH, 11'd0);
      q = make_sample(0, 16'sh7fff, 16'sh7fff, 0, 0);
      q.gated = 1'b1;
      pending_requests.push_back(q);
      pending_requests.push_back(make_sample(0, 16'sh7fff, 16'sh7fff, 0, 0));
      q = make_sample(1, 16'sd20000, 16'sd20000, 1, 16'd100);
      q.gated = 1'b1;
      pending_requests.push_back(q);
      pending_requests.push_back(make_sample(1, 16'sd20000, 16'sd20000, 1, 16'd100));
      q = '0;
      q.cmd = CMD_RELEASE;
      pending_requests.push_back(q);
      wait_idle();
      write_register(CSR_TOUCH, 11'd1);
      pending_requests.push_back(make_sample(0, 16'sd0, 16'sh8000, 0, 0));
      pending_requests.push_back(make_sample(1, 16'sd20000, 16'sd20000, 1, 16'd1));
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_SENS_H, 11'd0);
               write_register(CSR_SENS_V, 11'h7ff);
               write_register(CSR_INVERT_Y, 11'd1);
               write_register(CSR_CURVE, 11'd0);
            end
            1: begin
               write_register(CSR_SENS_H, 11'd1280);
               write_register(CSR_SENS_V, 11'd13);
               write_register(CSR_INVERT_Y, 11'd0);
               write_register(CSR_CURVE, 11'd1);
            end
            2: begin
               write_register(CSR_TOUCH, 11'd0);
            end
            3: begin
               write_register(CSR_TOUCH, 11'h7fe | 11'd1);
               write_register(CSR_SENS_H, 11'($urandom));
               write_register(CSR_SENS_V, 11'($urandom));
               calm_mode = 1'b1;
            end
            default: begin
               calm_mode = 1'b0;
               write_register(CSR_SENS_H, 11'($urandom_range(13, 1280)));
               write_register(CSR_SENS_V, 11'($urandom_range(13, 1280)));
               write_register(CSR_INVERT_Y, 11'($urandom));
               write_register(CSR_CURVE, 11'($urandom));
            end
         endcase
         for (int n = 0; n < 85; n++) pending_requests.push_back(random_request());
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
